### hdl/lts_pkg.sv
// Shared types and codes for the lift target motor sequencer.
`default_nettype none
package lts_pkg;

	// Field types of one command and one result transaction.
	typedef logic [1:0] op_t;
	typedef logic [2:0] value_t;
	typedef logic [1:0] drive_t;
	typedef logic [1:0] phase_t;

	// Command operations.
	localparam op_t OP_MODE  = 2'd0;
	localparam op_t OP_EVENT = 2'd1;
	localparam op_t OP_TICK  = 2'd2;

	// Mode codes.
	localparam value_t MD_WAITING = 3'd1;
	localparam value_t MD_STATIC  = 3'd2;
	localparam value_t MD_RANDOM  = 3'd3;

	// Event codes.
	localparam value_t EV_UP      = 3'd1;
	localparam value_t EV_UPLIM   = 3'd2;
	localparam value_t EV_DOWN    = 3'd3;
	localparam value_t EV_DOWNLIM = 3'd4;
	localparam value_t EV_SHOT    = 3'd5;

	// Bridge drive codes.
	localparam drive_t DRV_OFF    = 2'd0;
	localparam drive_t DRV_FWD    = 2'd1;
	localparam drive_t DRV_REV    = 2'd2;
	localparam drive_t DRV_UNUSED = 2'd3;

	// Sequence phases.
	localparam phase_t PH_UP       = 2'd0;
	localparam phase_t PH_UPWAIT   = 2'd1;
	localparam phase_t PH_DOWN     = 2'd2;
	localparam phase_t PH_DOWNWAIT = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_STEP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOT_HOLD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STATIC_PAUSE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LFSR_SEED    = 3'd4;

	// Reset values.
	localparam logic [13:0] RST_RANDOM_STEP  = 14'd500;
	localparam logic [9:0]  RST_TICK         = 10'd100;
	localparam logic [15:0] RST_SHOT_HOLD    = 16'd5000;
	localparam logic [7:0]  RST_STATIC_PAUSE = 8'd60;
	localparam logic [15:0] RST_HOLD         = 16'd1500;
	localparam logic [15:0] RST_LFSR         = 16'd1;
	localparam logic [15:0] LFSR_TAPS        = 16'hB400;

endpackage
`default_nettype wire

### hdl/lts_if.sv
// Valid/ready channel interfaces for command and result transactions.
`default_nettype none
interface lts_cmd_if import lts_pkg::*; ();
	logic   valid;
	logic   ready;
	op_t    op;
	value_t value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

interface lts_rsp_if import lts_pkg::*; ();
	logic   valid;
	logic   ready;
	drive_t drive;
	phase_t phase;

	modport source (output valid, output drive, output phase, input ready);
	modport sink   (input valid, input drive, input phase, output ready);
endinterface
`default_nettype wire

### hdl/lift_target_motor_sequencer.sv
// Lift target motor sequencer: latches modes and events, steps the H-bridge on each tick.
// Path: a command transaction accepted into the input register passes through one
// pass of next-state logic into the result register, which holds it until taken.
// Throughput: one command per cycle; the input stage stalls only while a result waits.
// Reset (arst_n low, asynchronous): drive off, all phases up, holds 1500 ms,
// LFSR at 1, configuration at its documented defaults, both channels empty.
`default_nettype none
module lift_target_motor_sequencer import lts_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	lts_cmd_if.sink              cmd,
	lts_rsp_if.source            rsp,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data
);

	// One Galois LFSR step, right shift.
	function automatic logic [15:0] lfsr_step(input logic [15:0] x);
		logic [15:0] y;
		y = x >> 1;
		if (x[0]) y = y ^ LFSR_TAPS;
		return y;
	endfunction

	// Remainder modulo 6 from base-4 digit folding (mod 3) and the parity bit.
	function automatic logic [2:0] mod6(input logic [15:0] x);
		logic [4:0] s;
		logic [2:0] t;
		logic [2:0] u;
		logic [1:0] r3;
		s = '0;
		for (int i = 0; i < 8; i++) s = s + 5'(x[2*i +: 2]);
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		u = 3'(t[1:0]) + 3'(t[2]);
		r3 = (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
		return (r3[0] == x[0]) ? {1'b0, r3} : 3'({1'b0, r3} + 3'd3);
	endfunction

	// Hold time from a fresh LFSR value: (value mod 6 + 1) * step, saturated.
	function automatic logic [15:0] hold_of(input logic [15:0] x, input logic [13:0] step);
		logic [16:0] p;
		p = 17'(step) * 17'(4'(mod6(x)) + 4'd1);
		return p[16] ? 16'hFFFF : p[15:0];
	endfunction

	// Saturating add of a tick to an elapsed counter.
	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [9:0] b);
		logic [16:0] s;
		s = 17'(a) + 17'(b);
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	// Configuration registers.
	logic [13:0] step_ms_q;
	logic [9:0]  tick_ms_q;
	logic [15:0] shot_hold_q;
	logic [7:0]  pause_ticks_q;

	// Sequencer state.
	value_t      mode_q, event_q;
	phase_t      sphase_q, rphase_q;
	logic [15:0] up_hold_q, down_hold_q, up_el_q, down_el_q, lfsr_q;
	logic [7:0]  pause_q;
	drive_t      drive_q;

	// Input stage and result register.
	logic   v_s1;
	op_t    op_s1;
	value_t value_s1;
	logic   rsp_valid_q;
	drive_t rsp_drive_q;
	phase_t rsp_phase_q;

	logic adv, step_en;
	assign adv       = !rsp_valid_q || rsp.ready;
	assign step_en   = v_s1 && adv;
	assign cmd.ready = !v_s1 || adv;
	assign rsp.valid = rsp_valid_q;
	assign rsp.drive = rsp_drive_q;
	assign rsp.phase = rsp_phase_q;

	// Next-state values.
	value_t      mode_n, event_n;
	phase_t      sphase_n, rphase_n, phase_n;
	logic [15:0] up_hold_n, down_hold_n, up_el_n, down_el_n, lfsr_n;
	logic [15:0] lfsr_a, lfsr_b, up_sum, down_sum;
	logic [7:0]  pause_n;
	drive_t      drive_n;

	assign lfsr_a   = lfsr_step(lfsr_q);
	assign lfsr_b   = lfsr_step(lfsr_a);
	assign up_sum   = sat_add(up_el_q, tick_ms_q);
	assign down_sum = sat_add(down_el_q, tick_ms_q);

	// One pass of the model step for the item in the input register.
	always_comb begin
		mode_n      = mode_q;
		event_n     = event_q;
		sphase_n    = sphase_q;
		rphase_n    = rphase_q;
		up_hold_n   = up_hold_q;
		down_hold_n = down_hold_q;
		up_el_n     = up_el_q;
		down_el_n   = down_el_q;
		lfsr_n      = lfsr_q;
		pause_n     = pause_q;
		drive_n     = drive_q;
		case (op_s1)
			OP_MODE:  mode_n = value_s1;
			OP_EVENT: event_n = value_s1;
			OP_TICK: begin
				if (pause_q != 8'd0) begin
					pause_n = pause_q - 8'd1;
				end else if (mode_q == MD_WAITING) begin
					drive_n = (event_q != EV_DOWN && event_q != EV_DOWNLIM) ? DRV_REV : DRV_OFF;
				end else if (mode_q == MD_STATIC) begin
					case (sphase_q)
						PH_UP: begin
							if (event_q != EV_UPLIM) begin
								drive_n = DRV_FWD;
							end else begin
								drive_n  = DRV_OFF;
								sphase_n = PH_UPWAIT;
							end
						end
						PH_UPWAIT: begin
							if (event_q == EV_SHOT) begin
								drive_n  = DRV_REV;
								sphase_n = PH_DOWN;
							end
						end
						PH_DOWN: begin
							if (event_q == EV_DOWNLIM) begin
								drive_n  = DRV_OFF;
								pause_n  = pause_ticks_q;
								sphase_n = PH_UP;
							end
						end
						default: ;
					endcase
				end else if (mode_q == MD_RANDOM) begin
					case (rphase_q)
						PH_UP: begin
							lfsr_n      = lfsr_b;
							up_hold_n   = hold_of(lfsr_a, step_ms_q);
							down_hold_n = hold_of(lfsr_b, step_ms_q);
							if (event_q != EV_UP && event_q != EV_UPLIM) begin
								drive_n = DRV_FWD;
							end else begin
								drive_n  = DRV_OFF;
								rphase_n = PH_UPWAIT;
							end
						end
						PH_UPWAIT: begin
							if (event_q == EV_SHOT) begin
								drive_n     = DRV_REV;
								up_el_n     = '0;
								down_hold_n = shot_hold_q;
								rphase_n    = PH_DOWN;
							end else if (up_sum > up_hold_q) begin
								drive_n  = DRV_REV;
								up_el_n  = '0;
								rphase_n = PH_DOWN;
							end else begin
								up_el_n = up_sum;
							end
						end
						PH_DOWN: begin
							if (event_q == EV_DOWNLIM) begin
								drive_n  = DRV_OFF;
								rphase_n = PH_DOWNWAIT;
							end
						end
						default: begin
							if (down_sum > down_hold_q) begin
								drive_n   = DRV_FWD;
								down_el_n = '0;
								rphase_n  = PH_UP;
							end else begin
								down_el_n = down_sum;
							end
						end
					endcase
				end
			end
			default: ;
		endcase
		if (mode_n == MD_STATIC)      phase_n = sphase_n;
		else if (mode_n == MD_RANDOM) phase_n = rphase_n;
		else                          phase_n = PH_UP;
	end

	// Input register and result register handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) v_s1 <= 1'b1;
			else if (adv)               v_s1 <= 1'b0;
			if (adv) rsp_valid_q <= v_s1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1    <= cmd.op;
			value_s1 <= cmd.value;
		end
		if (step_en) begin
			rsp_drive_q <= drive_n;
			rsp_phase_q <= phase_n;
		end
	end

	// Configuration writes and sequencer state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ms_q     <= RST_RANDOM_STEP;
			tick_ms_q     <= RST_TICK;
			shot_hold_q   <= RST_SHOT_HOLD;
			pause_ticks_q <= RST_STATIC_PAUSE;
			mode_q        <= '0;
			event_q       <= '0;
			sphase_q      <= PH_UP;
			rphase_q      <= PH_UP;
			up_hold_q     <= RST_HOLD;
			down_hold_q   <= RST_HOLD;
			up_el_q       <= '0;
			down_el_q     <= '0;
			pause_q       <= '0;
			lfsr_q        <= RST_LFSR;
			drive_q       <= DRV_OFF;
		end else begin
			if (step_en) begin
				mode_q      <= mode_n;
				event_q     <= event_n;
				sphase_q    <= sphase_n;
				rphase_q    <= rphase_n;
				up_hold_q   <= up_hold_n;
				down_hold_q <= down_hold_n;
				up_el_q     <= up_el_n;
				down_el_q   <= down_el_n;
				pause_q     <= pause_n;
				lfsr_q      <= lfsr_n;
				drive_q     <= drive_n;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RANDOM_STEP:  step_ms_q     <= cfg_data[13:0];
					CFG_TICK:         tick_ms_q     <= cfg_data[9:0];
					CFG_SHOT_HOLD:    shot_hold_q   <= cfg_data;
					CFG_STATIC_PAUSE: pause_ticks_q <= cfg_data[7:0];
					CFG_LFSR_SEED:    lfsr_q        <= (cfg_data == '0) ? RST_LFSR : cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

### hdl/lts_checker.sv
// Port-level assertions for the lift target motor sequencer, bound to the top level.
`default_nettype none
module lts_checker import lts_pkg::*; (
	input wire         clk,
	input wire         arst_n,
	input wire         cmd_valid,
	input wire         cmd_ready,
	input wire         rsp_valid,
	input wire         rsp_ready,
	input wire drive_t rsp_drive,
	input wire phase_t rsp_phase
);

	// A stalled result keeps its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_phase))
		else $error("result changed while stalled");

	// The unused drive code never reaches the bridge.
	a_drive_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_drive != DRV_UNUSED)
		else $error("reserved drive code on output");

	// Commands are refused only while a result waits to be taken.
	a_ready_skid: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> rsp_valid && !rsp_ready)
		else $error("command refused with result side free");

	// Every accepted command is followed by a valid result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |-> ##2 rsp_valid)
		else $error("no result two cycles after command");

endmodule

bind lift_target_motor_sequencer lts_checker u_lts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_drive (rsp.drive),
	.rsp_phase (rsp.phase)
);
`default_nettype wire

### bench/lts_bridge_checker.sv
// Checker for the lift target motor sequencer: predicts every result and compares it.
module lts_bridge_checker import lts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	lts_cmd_if                    cmd,
	lts_rsp_if                    rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    due_count,
	output int                    results_seen,
	output int                    lifts_done
);

	typedef struct packed {
		drive_t drive;
		phase_t phase;
	} bridge_state_t;

	// Only the first few mismatches are printed; all of them are counted.
	localparam int REPORT_LINES = 40;

	// Register copy.
	logic [13:0] step_ms;
	logic [9:0]  tick_len;
	logic [15:0] shot_hold;
	logic [7:0]  pause_ticks;

	// Sequencer state copy.
	value_t      mode_q;
	value_t      event_q;
	phase_t      static_phase_q;
	phase_t      random_phase_q;
	logic [15:0] up_hold;
	logic [15:0] down_hold;
	logic [15:0] up_elapsed;
	logic [15:0] down_elapsed;
	logic [7:0]  pause_left;
	logic [15:0] lfsr;
	drive_t      drive_q;

	// Expected results, oldest first.
	bridge_state_t bridge_due[$];

	function automatic logic [15:0] clip16(logic [31:0] v);
		return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < REPORT_LINES)
			$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic reset_state();
		step_ms        = RST_RANDOM_STEP;
		tick_len       = RST_TICK;
		shot_hold      = RST_SHOT_HOLD;
		pause_ticks    = RST_STATIC_PAUSE;
		lfsr           = RST_LFSR;
		mode_q         = '0;
		event_q        = '0;
		static_phase_q = PH_UP;
		random_phase_q = PH_UP;
		up_hold        = RST_HOLD;
		down_hold      = RST_HOLD;
		up_elapsed     = '0;
		down_elapsed   = '0;
		pause_left     = '0;
		drive_q        = DRV_OFF;
	endtask

	// Register writes keep only the bits of each field; a zero seed counts as one.
	task automatic load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_RANDOM_STEP:  step_ms = data[13:0];
			CFG_TICK:         tick_len = data[9:0];
			CFG_SHOT_HOLD:    shot_hold = data;
			CFG_STATIC_PAUSE: pause_ticks = data[7:0];
			CFG_LFSR_SEED:    lfsr = (data == '0) ? 16'd1 : data;
			default: ;
		endcase
	endtask

	// One right-shift Galois step, then a hold of one to six random steps.
	task automatic draw_hold(output logic [15:0] hold);
		logic lsb;
		lsb = lfsr[0];
		lfsr = lfsr >> 1;
		if (lsb)
			lfsr = lfsr ^ LFSR_TAPS;
		hold = clip16((32'(lfsr) % 6 + 1) * 32'(step_ms));
	endtask

	// Static mode: up to the up limit, wait for a shot, down to the down limit.
	task automatic step_static();
		case (static_phase_q)
			PH_UP: begin
				if (event_q != EV_UPLIM) begin
					drive_q = DRV_FWD;
				end else begin
					drive_q = DRV_OFF;
					static_phase_q = PH_UPWAIT;
				end
			end
			PH_UPWAIT: begin
				if (event_q == EV_SHOT) begin
					drive_q = DRV_REV;
					static_phase_q = PH_DOWN;
				end
			end
			PH_DOWN: begin
				if (event_q == EV_DOWNLIM) begin
					drive_q = DRV_OFF;
					pause_left = pause_ticks;
					static_phase_q = PH_UP;
					lifts_done++;
				end
			end
			default: ;
		endcase
	endtask

	// Random mode: up, hold (cut short by a shot), down, hold, then up again.
	task automatic step_random();
		case (random_phase_q)
			PH_UP: begin
				draw_hold(up_hold);
				draw_hold(down_hold);
				if (event_q != EV_UP && event_q != EV_UPLIM) begin
					drive_q = DRV_FWD;
				end else begin
					drive_q = DRV_OFF;
					random_phase_q = PH_UPWAIT;
				end
			end
			PH_UPWAIT: begin
				up_elapsed = clip16(32'(up_elapsed) + 32'(tick_len));
				if (event_q == EV_SHOT) begin
					drive_q = DRV_REV;
					up_elapsed = '0;
					down_hold = shot_hold;
					random_phase_q = PH_DOWN;
				end
				if (up_elapsed > up_hold) begin
					drive_q = DRV_REV;
					up_elapsed = '0;
					random_phase_q = PH_DOWN;
				end
			end
			PH_DOWN: begin
				if (event_q == EV_DOWNLIM) begin
					drive_q = DRV_OFF;
					random_phase_q = PH_DOWNWAIT;
				end
			end
			default: begin
				down_elapsed = clip16(32'(down_elapsed) + 32'(tick_len));
				if (down_elapsed > down_hold) begin
					drive_q = DRV_FWD;
					down_elapsed = '0;
					random_phase_q = PH_UP;
					lifts_done++;
				end
			end
		endcase
	endtask

	// A tick only counts down the static pause while one is running.
	task automatic do_tick();
		if (pause_left != '0) begin
			pause_left--;
		end else if (mode_q == MD_WAITING) begin
			if (event_q != EV_DOWN && event_q != EV_DOWNLIM)
				drive_q = DRV_REV;
			else
				drive_q = DRV_OFF;
		end else if (mode_q == MD_STATIC) begin
			step_static();
		end else if (mode_q == MD_RANDOM) begin
			step_random();
		end
	endtask

	// Applies one command and gives the drive and phase that it leaves.
	task automatic step_sequencer(op_t op, value_t val, output bridge_state_t res);
		case (op)
			OP_MODE:  mode_q = val;
			OP_EVENT: event_q = val;
			OP_TICK:  do_tick();
			default: ;
		endcase
		res.drive = drive_q;
		if (mode_q == MD_STATIC)
			res.phase = static_phase_q;
		else if (mode_q == MD_RANDOM)
			res.phase = random_phase_q;
		else
			res.phase = PH_UP;
	endtask

	// Results are matched before new commands are predicted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		bridge_state_t want;
		if (!arst_n) begin
			reset_state();
			bridge_due.delete();
			mismatches = 0;
			due_count = 0;
			results_seen = 0;
			lifts_done = 0;
		end else begin
			if (cfg_we)
				load_register(cfg_index, cfg_data);
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (bridge_due.size() == 0) begin
					report_mismatch($sformatf("result drive %0d phase %0d with nothing due",
						rsp.drive, rsp.phase));
				end else begin
					want = bridge_due.pop_front();
					if (rsp.drive !== want.drive)
						report_mismatch($sformatf("drive %0d, expected %0d",
							rsp.drive, want.drive));
					if (rsp.phase !== want.phase)
						report_mismatch($sformatf("phase %0d, expected %0d",
							rsp.phase, want.phase));
				end
			end
			if (cmd.valid && cmd.ready) begin
				step_sequencer(cmd.op, cmd.value, want);
				bridge_due.push_back(want);
			end
			due_count = bridge_due.size();
		end
	end

endmodule

### bench/tb_lift_target_motor_sequencer.sv
// Testbench top for the lift target motor sequencer: stimulus, stalls and verdict.
module tb_lift_target_motor_sequencer;
	import lts_pkg::*;

	// Codes that the package leaves unnamed.
	localparam op_t    OP_SPARE = 2'd3;
	localparam value_t VAL_NONE = 3'd0;
	localparam value_t MD_RADIO = 3'd4;
	localparam value_t EV_SPARE = 3'd6;
	localparam value_t VAL_TOP  = 3'd7;

	localparam int PERIOD        = 20;
	localparam int RESET_CYCLES  = 9;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 180;
	localparam int SETTLE_CYCLES = 4;
	localparam int IDLE_LIMIT    = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int due_count;
	int results_seen;
	int lifts_done;
	int items_sent;
	int phase_sent;
	bit steady;

	lts_cmd_if cmd_ch();
	lts_rsp_if rsp_ch();

	lift_target_motor_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lts_bridge_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_ch),
		.rsp          (rsp_ch),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.due_count    (due_count),
		.results_seen (results_seen),
		.lifts_done   (lifts_done)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Idle length: mostly none or short, now and then long; none in a steady stretch.
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (steady || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Offers one command transaction and returns at the edge that accepts it.
	task automatic send_cmd(op_t op, value_t val);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.op    <= op;
		cmd_ch.value <= val;
		do begin
			@(posedge clk);
		end while (!cmd_ch.ready);
		items_sent++;
		phase_sent++;
	endtask

	task automatic send_noise();
		send_cmd(op_t'($urandom_range(OP_SPARE)), value_t'($urandom_range(VAL_TOP)));
	endtask

	// A run of ticks, mostly short, sometimes long enough to ride out a hold.
	task automatic send_ticks();
		int r;
		int n;
		r = $urandom_range(99);
		if (r < 70)
			n = $urandom_range(4, 1);
		else if (r < 95)
			n = $urandom_range(15, 5);
		else
			n = $urandom_range(60, 16);
		repeat (n)
			send_cmd(OP_TICK, value_t'($urandom_range(VAL_TOP)));
	endtask

	// One lift cycle: a mode, then the events that carry it through, ticks in between.
	task automatic run_lift_cycle();
		int r;
		value_t mode;
		value_t evs[$];
		steady = ($urandom_range(7) == 0);
		r = $urandom_range(99);
		if (r < 40)
			mode = MD_STATIC;
		else if (r < 80)
			mode = MD_RANDOM;
		else if (r < 94)
			mode = MD_WAITING;
		else
			mode = value_t'($urandom_range(VAL_TOP));
		case (mode)
			MD_STATIC: evs = '{EV_UPLIM, EV_SHOT, EV_DOWNLIM};
			MD_RANDOM: begin
				evs.push_back($urandom_range(1) ? EV_UP : EV_UPLIM);
				if ($urandom_range(1))
					evs.push_back(EV_SHOT);
				evs.push_back(EV_DOWNLIM);
			end
			MD_WAITING: begin
				evs.push_back($urandom_range(1) ? EV_DOWN : EV_DOWNLIM);
				evs.push_back(VAL_NONE);
			end
			default: evs.push_back(value_t'($urandom_range(VAL_TOP)));
		endcase
		send_cmd(OP_MODE, mode);
		foreach (evs[i]) begin
			send_ticks();
			if ($urandom_range(99) < 12)
				send_noise();
			send_cmd(OP_EVENT, evs[i]);
		end
		send_ticks();
	endtask

	// Waits until every result is in and the pipeline has emptied.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (due_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Register settings: low values, longest tick; random ones; high values, shortest tick.
	task automatic load_setting(int p);
		logic [1:0] stray;
		stray = (p == 3) ? 2'($urandom) : 2'b0;
		case (p)
			1: begin
				write_reg(CFG_RANDOM_STEP, 16'd1);
				write_reg(CFG_TICK, 16'd1023);
				write_reg(CFG_SHOT_HOLD, 16'd0);
				write_reg(CFG_STATIC_PAUSE, 16'd0);
				write_reg(CFG_LFSR_SEED, 16'd0);
			end
			PHASES - 1: begin
				write_reg(CFG_RANDOM_STEP, 16'h3FFF);
				write_reg(CFG_TICK, 16'd1);
				write_reg(CFG_SHOT_HOLD, 16'hFFFF);
				write_reg(CFG_STATIC_PAUSE, 16'd255);
				write_reg(CFG_IDX_W'($urandom_range(7, CFG_LFSR_SEED + 1)), 16'($urandom));
				write_reg(CFG_LFSR_SEED, 16'hFFFF);
			end
			default: begin
				write_reg(CFG_RANDOM_STEP, {stray, 14'($urandom_range(300, 1))});
				write_reg(CFG_TICK, {stray, 4'b0, 10'($urandom_range(1000, 50))});
				write_reg(CFG_SHOT_HOLD, 16'($urandom_range(3000, 0)));
				write_reg(CFG_STATIC_PAUSE, {stray, 6'b0, 8'($urandom_range(4, 0))});
				write_reg(CFG_LFSR_SEED, 16'($urandom_range(65535, 1)));
			end
		endcase
		cfg_we <= 1'b0;
	endtask

	// Short directed pass over every operation and the odd codes.
	task automatic run_directed();
		send_cmd(OP_SPARE, VAL_TOP);
		send_cmd(OP_TICK, VAL_NONE);
		send_cmd(OP_MODE, MD_WAITING);
		send_cmd(OP_TICK, VAL_NONE);
		send_cmd(OP_EVENT, EV_DOWN);
		send_cmd(OP_TICK, VAL_TOP);
		send_cmd(OP_EVENT, EV_DOWNLIM);
		send_cmd(OP_TICK, VAL_NONE);
		send_cmd(OP_EVENT, VAL_TOP);
		send_cmd(OP_TICK, VAL_NONE);
		send_cmd(OP_MODE, MD_STATIC);
		send_cmd(OP_EVENT, VAL_NONE);
		send_cmd(OP_TICK, VAL_NONE);
		send_cmd(OP_EVENT, EV_UPLIM);
		send_cmd(OP_TICK, VAL_NONE);
		send_cmd(OP_EVENT, EV_SHOT);
		send_cmd(OP_TICK, VAL_NONE);
		send_cmd(OP_EVENT, EV_DOWNLIM);
		send_cmd(OP_TICK, VAL_NONE);
		send_cmd(OP_MODE, MD_RANDOM);
		send_cmd(OP_TICK, VAL_NONE);
		send_cmd(OP_EVENT, EV_SPARE);
		send_cmd(OP_MODE, MD_RADIO);
		send_cmd(OP_TICK, VAL_TOP);
		send_cmd(OP_MODE, VAL_TOP);
	endtask

	// Result side: ready in bursts with random stalls between them.
	initial begin : result_stall
		int g;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(6, 1)) @(posedge clk);
			g = gap_len();
			if (g != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	// Watchdog: too many cycles in a row without a transaction on either channel.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timeout after %0d cycles without a transaction.", IDLE_LIMIT);
		$display("tb_lift_target_motor_sequencer NOT OK");
		$finish;
	end

	// Stimulus: reset, directed pass, then one random phase per register setting.
	initial begin : stimulus
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.op    <= OP_MODE;
		cmd_ch.value <= VAL_NONE;
		steady = 1'b0;
		items_sent = 0;
		phase_sent = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				settle();
				load_setting(p);
			end
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS)
				run_lift_cycle();
		end
		settle();
		@(negedge clk);
		$display("Sent %0d command transactions over %0d register settings, checked %0d results.",
			items_sent, PHASES, results_seen);
		$display("Predicted %0d finished lift cycles in static or random mode, %0d mismatches.",
			lifts_done, mismatches);
		if (mismatches == 0 && due_count == 0)
			$display("tb_lift_target_motor_sequencer OK");
		else
			$display("tb_lift_target_motor_sequencer NOT OK");
		$finish;
	end

endmodule
